/* rtl/core/ptpa_pkg.sv */
// ----------------------------------------------------------------------------
// ptpa_pkg
// Shared constants, codes and payload types for the planar tile pixel access
// block.
// ----------------------------------------------------------------------------
package ptpa_pkg;

	localparam int MEM_BYTES = 65536;
	localparam int MEM_AW    = $clog2(MEM_BYTES);
	localparam int LANE_W    = 4;
	localparam int ROW_BYTES = 1 << LANE_W;
	localparam int ROW_W     = ROW_BYTES * 8;
	localparam int ROWS      = MEM_BYTES / ROW_BYTES;
	localparam int ROW_AW    = MEM_AW - LANE_W;
	localparam int TILE_W    = 12;
	localparam int SIZE_W    = 17;
	localparam int END_W     = 18;
	localparam int NPLANES   = 4;

	localparam int CFG_IW = 1;
	localparam int CFG_DW = 17;

	localparam logic [CFG_IW-1:0] CFG_TILE_FORMAT = 1'd0;
	localparam logic [CFG_IW-1:0] CFG_IMAGE_SIZE  = 1'd1;

	localparam logic [1:0] KIND_PIX_RD  = 2'd0;
	localparam logic [1:0] KIND_PIX_WR  = 2'd1;
	localparam logic [1:0] KIND_BYTE_WR = 2'd2;
	localparam logic [1:0] KIND_BYTE_RD = 2'd3;

	localparam logic [1:0] FMT_SPLIT2 = 2'd0;
	localparam logic [1:0] FMT_INTER2 = 2'd1;
	localparam logic [1:0] FMT_INTER4 = 2'd2;

	localparam logic [1:0]        TILE_FORMAT_RST = FMT_SPLIT2;
	localparam logic [SIZE_W-1:0] IMAGE_SIZE_RST  = 17'd40960;

	typedef struct packed {
		logic [1:0]        kind;
		logic [TILE_W-1:0] tile_index;
		logic [2:0]        pixel_x;
		logic [2:0]        pixel_y;
		logic [3:0]        pixel_color;
		logic [15:0]       byte_address;
		logic [7:0]        byte_value;
	} in_t;

	typedef struct packed {
		logic [3:0] color_out;
		logic [7:0] byte_out;
		logic       out_of_range;
	} out_t;

endpackage

/* rtl/core/planar_tile_pixel_access.sv */
// ----------------------------------------------------------------------------
// planar_tile_pixel_access
// Tile graphics memory with pixel read/write in three planar layouts and raw
// byte access.
// ----------------------------------------------------------------------------
// channel   ports                          transfer
// command   start, busy, cmd               start & !busy at rising edge
// result    done, result                   done high for one cycle
// config    cfg_we, cfg_index, cfg_data    cfg_we at rising edge
//
// Every command does a row read of the 16-byte-wide memory, then merge and,
// for writes, write-back of the same row in the following cycle.
// busy is high for the cycle after a command transfer; done follows in the
// cycle after busy, so a new command can be taken in the cycle done is shown.
// Reset clears control and loads the configuration reset values; memory contents are undefined.
// The result side cannot stall.
// ----------------------------------------------------------------------------
module planar_tile_pixel_access (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  ptpa_pkg::in_t                 cmd,
	output logic                          done,
	output ptpa_pkg::out_t                result,
	input  logic                          cfg_we,
	input  logic [ptpa_pkg::CFG_IW-1:0]   cfg_index,
	input  logic [ptpa_pkg::CFG_DW-1:0]   cfg_data
);

	logic [1:0]                    tile_format_q;
	logic [ptpa_pkg::SIZE_W-1:0]   image_size_q;
	logic                          busy_q;
	logic                          done_q;
	ptpa_pkg::out_t                result_q;

	logic [ptpa_pkg::ROW_W-1:0]    mem_q [ptpa_pkg::ROWS];
	logic [ptpa_pkg::ROW_W-1:0]    rd_data_q;

	logic                          accept;
	logic                          is_raw;
	logic                          fmt_ok;
	logic                          wide;
	logic [ptpa_pkg::END_W-1:0]    base;
	logic [ptpa_pkg::END_W-1:0]    tile_end;
	logic [ptpa_pkg::SIZE_W-1:0]   limit;
	logic                          tile_oor;
	logic                          raw_oor;
	logic                          pix_act;
	logic [ptpa_pkg::ROW_AW-1:0]   row;
	logic [ptpa_pkg::LANE_W-1:0]   lane [ptpa_pkg::NPLANES];
	logic [ptpa_pkg::NPLANES-1:0]  plane_use;

	logic [1:0]                    kind_s1;
	logic [ptpa_pkg::LANE_W-1:0]   lane_s1 [ptpa_pkg::NPLANES];
	logic [ptpa_pkg::NPLANES-1:0]  use_s1;
	logic [2:0]                    px_s1;
	logic [3:0]                    color_s1;
	logic [7:0]                    bval_s1;
	logic [ptpa_pkg::ROW_AW-1:0]   row_s1;
	logic                          oor_s1;
	logic                          act_s1;

	logic [3:0]                    color_rd;
	logic [7:0]                    byte0;
	logic [ptpa_pkg::ROW_W-1:0]    wr_data;
	logic                          wr_en;
	ptpa_pkg::out_t                res_next;

	assign accept = start & ~busy_q;
	assign busy   = busy_q;
	assign done   = done_q;
	assign result = result_q;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tile_format_q <= ptpa_pkg::TILE_FORMAT_RST;
			image_size_q  <= ptpa_pkg::IMAGE_SIZE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				ptpa_pkg::CFG_TILE_FORMAT: tile_format_q <= cfg_data[1:0];
				ptpa_pkg::CFG_IMAGE_SIZE:  image_size_q  <= cfg_data[ptpa_pkg::SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	// command decode
	always_comb begin
		is_raw = (cmd.kind == ptpa_pkg::KIND_BYTE_WR) || (cmd.kind == ptpa_pkg::KIND_BYTE_RD);
		fmt_ok = (tile_format_q == ptpa_pkg::FMT_SPLIT2) ||
		         (tile_format_q == ptpa_pkg::FMT_INTER2) ||
		         (tile_format_q == ptpa_pkg::FMT_INTER4);
		wide   = (tile_format_q == ptpa_pkg::FMT_INTER4);
		base   = wide ? (ptpa_pkg::END_W'(cmd.tile_index) << 5)
		              : (ptpa_pkg::END_W'(cmd.tile_index) << 4);
		tile_end = base + (wide ? ptpa_pkg::END_W'(32) : ptpa_pkg::END_W'(16));
		limit  = (image_size_q > ptpa_pkg::SIZE_W'(ptpa_pkg::MEM_BYTES))
		         ? ptpa_pkg::SIZE_W'(ptpa_pkg::MEM_BYTES) : image_size_q;
		tile_oor = tile_end > ptpa_pkg::END_W'(limit);
		raw_oor  = ptpa_pkg::END_W'(cmd.byte_address) >= ptpa_pkg::END_W'(ptpa_pkg::MEM_BYTES);
		pix_act  = ~is_raw & fmt_ok & ~tile_oor;

		for (int j = 0; j < ptpa_pkg::NPLANES; j++) begin
			lane[j] = '0;
		end
		plane_use = '0;
		row = ptpa_pkg::ROW_AW'(cmd.tile_index);
		if (is_raw) begin
			row     = cmd.byte_address[ptpa_pkg::MEM_AW-1:ptpa_pkg::LANE_W];
			lane[0] = cmd.byte_address[ptpa_pkg::LANE_W-1:0];
		end else begin
			case (tile_format_q)
				ptpa_pkg::FMT_SPLIT2: begin
					lane[1]   = {1'b0, cmd.pixel_y};
					lane[0]   = {1'b1, cmd.pixel_y};
					plane_use = 4'b0011;
				end
				ptpa_pkg::FMT_INTER2: begin
					lane[1]   = {cmd.pixel_y, 1'b0};
					lane[0]   = {cmd.pixel_y, 1'b1};
					plane_use = 4'b0011;
				end
				ptpa_pkg::FMT_INTER4: begin
					row = ptpa_pkg::ROW_AW'({cmd.tile_index, cmd.pixel_y[2]});
					for (int j = 0; j < ptpa_pkg::NPLANES; j++) begin
						lane[j] = {cmd.pixel_y[1:0], 2'(j)};
					end
					plane_use = 4'b1111;
				end
				default: plane_use = '0;
			endcase
			if (!pix_act) begin
				plane_use = '0;
			end
		end
	end

	// stage 1 registers
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1  <= cmd.kind;
			lane_s1  <= lane;
			use_s1   <= plane_use;
			px_s1    <= cmd.pixel_x;
			color_s1 <= cmd.pixel_color;
			bval_s1  <= cmd.byte_value;
			row_s1   <= row;
			oor_s1   <= is_raw ? raw_oor : (fmt_ok & tile_oor);
			act_s1   <= is_raw ? ~raw_oor : pix_act;
		end
	end

	// graphics memory
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_data_q <= mem_q[row];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[row_s1] <= wr_data;
		end
	end

	// merge and result
	always_comb begin
		logic [7:0] pb;
		color_rd = '0;
		wr_data  = rd_data_q;
		byte0    = rd_data_q[{lane_s1[0], 3'b000} +: 8];
		for (int j = 0; j < ptpa_pkg::NPLANES; j++) begin
			pb = rd_data_q[{lane_s1[j], 3'b000} +: 8];
			color_rd[j] = use_s1[j] & pb[px_s1];
			if (use_s1[j] && kind_s1 == ptpa_pkg::KIND_PIX_WR) begin
				wr_data[{lane_s1[j], px_s1}] = color_s1[j];
			end
		end
		if (act_s1 && kind_s1 == ptpa_pkg::KIND_BYTE_WR) begin
			wr_data[{lane_s1[0], 3'b000} +: 8] = bval_s1;
		end
		wr_en = busy_q & act_s1 &
		        ((kind_s1 == ptpa_pkg::KIND_PIX_WR) || (kind_s1 == ptpa_pkg::KIND_BYTE_WR));

		res_next.color_out    = (kind_s1 == ptpa_pkg::KIND_PIX_RD) ? color_rd : 4'd0;
		res_next.byte_out     = (act_s1 && kind_s1 == ptpa_pkg::KIND_BYTE_RD) ? byte0 : 8'd0;
		res_next.out_of_range = oor_s1;
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			result_q <= res_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			busy_q <= accept;
			done_q <= busy_q;
		end
	end

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy_q)
		else $error("command transfer not followed by busy");

	a_busy_done: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |=> done_q && !busy_q)
		else $error("busy cycle not followed by a single result");

	a_write_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> busy_q && !oor_s1)
		else $error("memory write outside busy or on refused access");

	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && result_q.out_of_range |-> result_q.color_out == 4'd0 &&
		result_q.byte_out == 8'd0)
		else $error("refused access returned data");

endmodule

/* tb/tb_planar_tile_pixel_access.sv */
// ----------------------------------------------------------------------------
// tb_planar_tile_pixel_access
// Self-checking bench for the planar tile pixel access block. Drives pixel and
// raw byte commands under changing layout and image size settings, predicts
// each result from a shadow copy of the graphics memory and compares every
// result field. Tiles are loaded by raw writes before their pixels are used.
// ----------------------------------------------------------------------------
module tb_planar_tile_pixel_access;
	timeunit 1ns;
	timeprecision 1ps;

	import ptpa_pkg::*;

	localparam logic [1:0] FMT_UNUSED = 2'd3;
	localparam int STALL_LIMIT  = 2000;
	localparam int PHASES       = 10;
	localparam int PHASE_ITEMS  = 183;
	localparam int SETTLE_CYCLES = 4;

	class tile_store_checker;
		logic [7:0]        plane_mem [MEM_BYTES];
		logic [1:0]        layout;
		logic [SIZE_W-1:0] valid_bytes;
		out_t              awaited [$];
		int                mismatches;

		function new();
			foreach (plane_mem[i]) plane_mem[i] = '0;
			layout      = TILE_FORMAT_RST;
			valid_bytes = IMAGE_SIZE_RST;
			mismatches  = 0;
		endfunction

		function void set_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] data);
			if (idx == CFG_TILE_FORMAT) layout = data[1:0];
			else if (idx == CFG_IMAGE_SIZE) valid_bytes = data[SIZE_W-1:0];
		endfunction

		function void predict_access(in_t c);
			out_t        r;
			int unsigned tile_bytes, base, lim, planes;
			int unsigned addr [4];
			logic [3:0]  weight [4];
			logic [7:0]  bit_mask;
			r = '0;
			if (c.kind == KIND_BYTE_WR || c.kind == KIND_BYTE_RD) begin
				if (c.byte_address >= MEM_BYTES) r.out_of_range = 1'b1;
				else if (c.kind == KIND_BYTE_WR) plane_mem[c.byte_address] = c.byte_value;
				else r.byte_out = plane_mem[c.byte_address];
			end else if (layout != FMT_UNUSED) begin
				tile_bytes = (layout == FMT_INTER4) ? 32 : 16;
				base = c.tile_index * tile_bytes;
				lim  = (valid_bytes > MEM_BYTES) ? MEM_BYTES : valid_bytes;
				if (base + tile_bytes > lim) begin
					r.out_of_range = 1'b1;
				end else begin
					bit_mask = 8'd1 << c.pixel_x;
					case (layout)
						FMT_SPLIT2: begin
							addr[0] = base + c.pixel_y;      weight[0] = 4'd2;
							addr[1] = base + 8 + c.pixel_y;  weight[1] = 4'd1;
							planes = 2;
						end
						FMT_INTER2: begin
							addr[0] = base + 2 * c.pixel_y;     weight[0] = 4'd2;
							addr[1] = base + 2 * c.pixel_y + 1; weight[1] = 4'd1;
							planes = 2;
						end
						default: begin
							for (int k = 0; k < 4; k++) begin
								addr[k]   = base + 4 * c.pixel_y + k;
								weight[k] = 4'd1 << k;
							end
							planes = 4;
						end
					endcase
					for (int k = 0; k < planes; k++) begin
						if (c.kind == KIND_PIX_RD) begin
							if ((plane_mem[addr[k]] & bit_mask) != 0) r.color_out |= weight[k];
						end else if ((c.pixel_color & weight[k]) != 0) begin
							plane_mem[addr[k]] = plane_mem[addr[k]] | bit_mask;
						end else begin
							plane_mem[addr[k]] = plane_mem[addr[k]] & ~bit_mask;
						end
					end
				end
			end
			awaited.push_back(r);
		endfunction

		function void check_output(out_t got);
			out_t exp;
			if (awaited.size() == 0) begin
				$error("result with no command outstanding");
				mismatches++;
				return;
			end
			exp = awaited.pop_front();
			if (got.color_out !== exp.color_out) begin
				$error("color_out: expected %0d, got %0d", exp.color_out, got.color_out);
				mismatches++;
			end
			if (got.byte_out !== exp.byte_out) begin
				$error("byte_out: expected %0d, got %0d", exp.byte_out, got.byte_out);
				mismatches++;
			end
			if (got.out_of_range !== exp.out_of_range) begin
				$error("out_of_range: expected %0d, got %0d", exp.out_of_range,
					got.out_of_range);
				mismatches++;
			end
		endfunction

		function int pending();
			return awaited.size();
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n;
	logic                start;
	logic                busy;
	in_t                 cmd;
	logic                done;
	out_t                result;
	logic                cfg_we;
	logic [CFG_IW-1:0]   cfg_index;
	logic [CFG_DW-1:0]   cfg_data;

	tile_store_checker   store = new();
	bit                  loaded [MEM_BYTES];
	int unsigned         loaded_addrs [$];
	logic [1:0]          cur_fmt = TILE_FORMAT_RST;
	int unsigned         cur_size = IMAGE_SIZE_RST;
	int                  max_gap = 16;
	int                  sent = 0;
	int                  stall_cycles = 0;

	planar_tile_pixel_access i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.done      (done),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (done) store.check_output(result);
			if (start && !busy) store.predict_access(cmd);
			if (cfg_we) store.set_reg(cfg_index, cfg_data);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done || cfg_we) begin
				stall_cycles <= 0;
			end else if (stall_cycles >= STALL_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	function automatic in_t noisy_cmd(logic [1:0] kind);
		logic [63:0] r;
		in_t         c;
		r = {$urandom(), $urandom()};
		c = in_t'(r[$bits(in_t)-1:0]);
		c.kind = kind;
		return c;
	endfunction

	function automatic int unsigned size_limit();
		return (cur_size > MEM_BYTES) ? MEM_BYTES : cur_size;
	endfunction

	// called in the step of the previous transfer, so start never drops and rises at once
	task automatic issue(in_t c);
		int gap;
		gap = (max_gap == 0 || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, max_gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		cmd   <= c;
		do @(posedge clk); while (busy);
		sent++;
	endtask

	task automatic settle();
		start <= 1'b0;
		while (store.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_TILE_FORMAT) cur_fmt = data[1:0];
		else cur_size = data[SIZE_W-1:0];
		@(posedge clk);
	endtask

	task automatic raw_write(int unsigned a, logic [7:0] v);
		in_t c;
		c = noisy_cmd(KIND_BYTE_WR);
		c.byte_address = a[15:0];
		c.byte_value   = v;
		if (!loaded[a]) begin
			loaded[a] = 1'b1;
			loaded_addrs.push_back(a);
		end
		issue(c);
	endtask

	task automatic raw_read(int unsigned a);
		in_t c;
		c = noisy_cmd(KIND_BYTE_RD);
		c.byte_address = a[15:0];
		issue(c);
	endtask

	// loads any unwritten byte of an in-range tile before touching its pixels
	task automatic pixel_access(logic [1:0] op, int unsigned tile, logic [2:0] x,
			logic [2:0] y, logic [3:0] color);
		in_t         c;
		int unsigned tbytes, first;
		tbytes = (cur_fmt == FMT_INTER4) ? 32 : 16;
		first  = tile * tbytes;
		if (cur_fmt != FMT_UNUSED && first + tbytes <= size_limit())
			for (int unsigned a = first; a < first + tbytes; a++)
				if (!loaded[a]) raw_write(a, 8'($urandom_range(0, 255)));
		c = noisy_cmd(op);
		c.tile_index  = tile[TILE_W-1:0];
		c.pixel_x     = x;
		c.pixel_y     = y;
		c.pixel_color = color;
		issue(c);
	endtask

	function automatic int unsigned pick_tile();
		int r, tbytes, last_fit, t;
		r        = $urandom_range(0, 99);
		tbytes   = (cur_fmt == FMT_INTER4) ? 32 : 16;
		last_fit = int'(size_limit()) / tbytes - 1;
		if (r < 80) return $urandom_range(0, 7);
		if (r < 94) begin
			t = last_fit - 1 + $urandom_range(0, 2);
			if (t < 0) t = 0;
			if (t > 4095) t = 4095;
			return t;
		end
		return $urandom_range(0, 4095);
	endfunction

	task automatic random_item();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			pixel_access($urandom_range(0, 1) ? KIND_PIX_WR : KIND_PIX_RD, pick_tile(),
				3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
				4'($urandom_range(0, 15)));
		else if (r < 75 && loaded_addrs.size() > 0)
			raw_read(loaded_addrs[$urandom_range(0, loaded_addrs.size() - 1)]);
		else
			raw_write(($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
				: $urandom_range(0, 511), 8'($urandom_range(0, 255)));
	endtask

	task automatic configure_phase(int p);
		logic [1:0]  f;
		int unsigned sz;
		case (p)
			0: begin f = FMT_INTER2; sz = 65536; end
			1: begin f = FMT_INTER4; sz = 131071; end
			2: begin f = FMT_SPLIT2; sz = 32; end
			3: begin f = FMT_INTER4; sz = 0; end
			4: begin f = FMT_UNUSED; sz = 65536; end
			5: begin f = FMT_INTER2; sz = 16; end
			6: begin f = FMT_INTER4; sz = 31; end
			7: begin f = FMT_SPLIT2; sz = 65535; end
			8: begin f = FMT_INTER4; sz = $urandom_range(32, 65536); end
			default: begin f = 2'($urandom_range(0, 3)); sz = $urandom_range(0, 131071); end
		endcase
		write_reg(CFG_TILE_FORMAT, {15'($urandom()), f});
		write_reg(CFG_IMAGE_SIZE, sz[CFG_DW-1:0]);
		max_gap = (p % 3 == 0) ? 0 : ((p % 3 == 1) ? 16 : 3);
	endtask

	initial begin
		int directed_items;
		arst_n    = 1'b0;
		start     = 1'b0;
		cmd       = '0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: split two-plane layout, 40960 valid bytes
		raw_write(65535, 8'hFF);
		raw_read(65535);
		raw_write(0, 8'h00);
		pixel_access(KIND_PIX_WR, 0, 3'd7, 3'd7, 4'hF);
		pixel_access(KIND_PIX_RD, 0, 3'd7, 3'd7, 4'h0);
		pixel_access(KIND_PIX_RD, 0, 3'd0, 3'd0, 4'h0);
		pixel_access(KIND_PIX_WR, 0, 3'd0, 3'd0, 4'h0);
		raw_read(8);
		pixel_access(KIND_PIX_RD, 4095, 3'd3, 3'd4, 4'h0);
		pixel_access(KIND_PIX_WR, 2560, 3'd1, 3'd2, 4'hF);
		settle();
		write_reg(CFG_TILE_FORMAT, {15'd0, FMT_UNUSED});
		pixel_access(KIND_PIX_RD, 0, 3'd3, 3'd5, 4'h0);
		pixel_access(KIND_PIX_WR, 0, 3'd3, 3'd5, 4'hA);
		directed_items = sent;

		for (int p = 0; p < PHASES; p++) begin
			settle();
			configure_phase(p);
			while (sent < directed_items + (p + 1) * PHASE_ITEMS) random_item();
		end

		settle();
		repeat (8) @(posedge clk);
		if (store.mismatches == 0 && store.pending() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
